// ----- src/dn2cd_pkg.sv -----
`timescale 1ns / 1ps

package dn2cd_pkg;

    // First day number dated in the Gregorian calendar (15 Oct 1582).
    localparam logic [21:0] GREG_START     = 22'd2299161;
    // Day number of 1 Jan of year 1 in the proleptic Gregorian count.
    localparam logic [21:0] GREG_EPOCH     = 22'd1721426;

    // Day counts of the calendar cycles.
    localparam logic [21:0] QUAD_DAYS      = 22'd1461;
    localparam logic [21:0] CYCLE_DAYS     = 22'd146097;
    localparam logic [17:0] THREE_CENT     = 18'd109572;
    localparam logic [17:0] TWO_CENT       = 18'd73048;
    localparam logic [17:0] CENTURY_DAYS   = 18'd36524;
    localparam logic [15:0] CENT_LAST_QUAD = 16'd35064;

    // Reciprocals scaled by 2^32; the quotient estimate is low by at most one.
    localparam logic [21:0] RECIP_QUAD     = 22'd2939744;
    localparam logic [21:0] RECIP_CYCLE    = 22'd29398;

    // Year offset of the Julian count (day 0 lies in year -4712).
    localparam logic [13:0] JUL_YEAR0      = 14'd4712;
    // Quad index of the short last quad of a century.
    localparam logic [4:0]  LAST_QUAD_IDX  = 5'd24;
    localparam logic [1:0]  LAST_CENT_IDX  = 2'd3;

    // Stage bundle after the first division: Julian quad or 400-year cycle.
    typedef struct packed {
        logic        valid;
        logic        jul;
        logic [10:0] q;
        logic [17:0] rem;
    } cyc_t;

    // Stage bundle after the century and quad split.
    typedef struct packed {
        logic        valid;
        logic        jul;
        logic [10:0] q;
        logic [1:0]  cent;
        logic [4:0]  quad;
        logic [10:0] rq;
    } quad_t;

    // Day of year on which a month starts, month index counted from zero.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        logic       add_leap;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        add_leap = leap && (idx >= 4'd2);
        return base + {8'd0, add_leap};
    endfunction

endpackage

// ----- src/day_number_to_calendar_date_unit.sv -----
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// --------+----------------------+---------------------------------------------
// input   | in_valid / in_ready  | day_number[21:0]
// output  | out_valid / out_ready| year[13:0] signed, month[3:0], day[4:0]
//
// Eleven register stages; an item enters every cycle in which the output is
// not stalled. The two reciprocal multipliers and their correction steps set
// the depth. All stages advance together and hold while a result waits at the
// output, so a stall loses or repeats no item. Reset clears only the valid
// bits of the stages.

module day_number_to_calendar_date_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [21:0]        day_number,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [13:0] year,
    output logic [3:0]         month,
    output logic [4:0]         day
);

    dn2cd_pkg::cyc_t  cyc;
    dn2cd_pkg::quad_t qd;
    logic             en;

    // The pipeline moves whenever the output register is empty or being taken.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    dn2cd_cycle_div u_cycle_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .day_number (day_number),
        .cyc        (cyc)
    );

    dn2cd_cycle_split u_cycle_split (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cyc   (cyc),
        .qo    (qd)
    );

    dn2cd_date_build u_date_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .qi        (qd),
        .out_valid (out_valid),
        .year      (year),
        .month     (month),
        .day       (day)
    );

endmodule

// ----- src/dn2cd_cycle_div.sv -----
`timescale 1ns / 1ps

module dn2cd_cycle_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [21:0]         day_number,
    output dn2cd_pkg::cyc_t     cyc
);

    logic        s1_valid_reg;
    logic        s1_jul_reg;
    logic [21:0] s1_v_reg;

    logic        s2_valid_reg;
    logic        s2_jul_reg;
    logic [21:0] s2_v_reg;
    logic [10:0] s2_q_reg;

    logic        s3_valid_reg;
    logic        s3_jul_reg;
    logic [21:0] s3_v_reg;
    logic [10:0] s3_q_reg;
    logic [21:0] s3_prodq_reg;

    logic        s4_valid_reg;
    logic        s4_jul_reg;
    logic [10:0] s4_q_reg;
    logic [18:0] s4_rem0_reg;

    logic        s5_valid_reg;
    logic        s5_jul_reg;
    logic [10:0] s5_q_reg;
    logic [17:0] s5_rem_reg;

    logic        s1_jul_next;
    logic [21:0] s1_v_next;
    logic [21:0] s2_recip;
    logic [43:0] s2_prod;
    logic [21:0] s3_div;
    logic [21:0] s3_prodq_next;
    logic [21:0] s4_diff;
    logic [18:0] s5_div;
    logic [18:0] s5_sub;
    logic [10:0] s5_q_next;
    logic [17:0] s5_rem_next;

    // Pick the calendar and move the Gregorian count to start at year 1.
    always_comb
    begin
        s1_jul_next = day_number < dn2cd_pkg::GREG_START;
        s1_v_next   = s1_jul_next ? day_number : day_number - dn2cd_pkg::GREG_EPOCH;
    end

    // Quotient estimate by the scaled reciprocal of the cycle length.
    always_comb
    begin
        s2_recip = s1_jul_reg ? dn2cd_pkg::RECIP_QUAD : dn2cd_pkg::RECIP_CYCLE;
        s2_prod  = {22'd0, s1_v_reg} * {22'd0, s2_recip};
    end

    // Multiply the estimate back by the cycle length.
    always_comb
    begin
        s3_div        = s2_jul_reg ? dn2cd_pkg::QUAD_DAYS : dn2cd_pkg::CYCLE_DAYS;
        s3_prodq_next = {11'd0, s2_q_reg} * s3_div;
    end

    // Raw remainder, below twice the cycle length.
    assign s4_diff = s3_v_reg - s3_prodq_reg;

    // One correction step makes the quotient exact.
    always_comb
    begin
        s5_div = s4_jul_reg ? dn2cd_pkg::QUAD_DAYS[18:0] : dn2cd_pkg::CYCLE_DAYS[18:0];
        s5_sub = s4_rem0_reg - s5_div;
        if (s4_rem0_reg >= s5_div)
        begin
            s5_q_next   = s4_q_reg + 11'd1;
            s5_rem_next = s5_sub[17:0];
        end
        else
        begin
            s5_q_next   = s4_q_reg;
            s5_rem_next = s4_rem0_reg[17:0];
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Payload of the stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_jul_reg   <= s1_jul_next;
            s1_v_reg     <= s1_v_next;

            s2_jul_reg   <= s1_jul_reg;
            s2_v_reg     <= s1_v_reg;
            s2_q_reg     <= s2_prod[42:32];

            s3_jul_reg   <= s2_jul_reg;
            s3_v_reg     <= s2_v_reg;
            s3_q_reg     <= s2_q_reg;
            s3_prodq_reg <= s3_prodq_next;

            s4_jul_reg   <= s3_jul_reg;
            s4_q_reg     <= s3_q_reg;
            s4_rem0_reg  <= s4_diff[18:0];

            s5_jul_reg   <= s4_jul_reg;
            s5_q_reg     <= s5_q_next;
            s5_rem_reg   <= s5_rem_next;
        end
    end

    assign cyc.valid = s5_valid_reg;
    assign cyc.jul   = s5_jul_reg;
    assign cyc.q     = s5_q_reg;
    assign cyc.rem   = s5_rem_reg;

endmodule

// ----- src/dn2cd_cycle_split.sv -----
`timescale 1ns / 1ps

module dn2cd_cycle_split (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  dn2cd_pkg::cyc_t     cyc,
    output dn2cd_pkg::quad_t    qo
);

    logic        s6_valid_reg;
    logic        s6_jul_reg;
    logic [10:0] s6_q_reg;
    logic [1:0]  s6_cent_reg;
    logic [15:0] s6_m_reg;
    logic        s6_last_reg;

    logic        s7_valid_reg;
    logic        s7_jul_reg;
    logic [10:0] s7_q_reg;
    logic [1:0]  s7_cent_reg;
    logic [15:0] s7_m_reg;
    logic        s7_last_reg;
    logic [4:0]  s7_qe_reg;

    logic        s8_valid_reg;
    logic        s8_jul_reg;
    logic [10:0] s8_q_reg;
    logic [1:0]  s8_cent_reg;
    logic [15:0] s8_m_reg;
    logic        s8_last_reg;
    logic [4:0]  s8_qe_reg;
    logic [11:0] s8_r_reg;

    logic        s9_valid_reg;
    logic        s9_jul_reg;
    logic [10:0] s9_q_reg;
    logic [1:0]  s9_cent_reg;
    logic [4:0]  s9_quad_reg;
    logic [10:0] s9_rq_reg;

    logic [1:0]  s6_cent_next;
    logic [17:0] s6_sub;
    logic [15:0] s6_m_next;
    logic        s6_last_next;
    logic [37:0] s7_prod;
    logic [15:0] s8_back;
    logic [15:0] s8_diff;
    logic [11:0] s9_rsub;
    logic [15:0] s9_msub;
    logic [4:0]  s9_quad_next;
    logic [10:0] s9_rq_next;

    // Split the 400-year cycle into centuries; the fourth one has a leap end year.
    always_comb
    begin
        s6_cent_next = 2'd0;
        s6_sub       = cyc.rem;
        if (!cyc.jul)
        begin
            if (cyc.rem >= dn2cd_pkg::THREE_CENT)
            begin
                s6_cent_next = 2'd3;
                s6_sub       = cyc.rem - dn2cd_pkg::THREE_CENT;
            end
            else if (cyc.rem >= dn2cd_pkg::TWO_CENT)
            begin
                s6_cent_next = 2'd2;
                s6_sub       = cyc.rem - dn2cd_pkg::TWO_CENT;
            end
            else if (cyc.rem >= dn2cd_pkg::CENTURY_DAYS)
            begin
                s6_cent_next = 2'd1;
                s6_sub       = cyc.rem - dn2cd_pkg::CENTURY_DAYS;
            end
        end
        s6_m_next    = s6_sub[15:0];
        // A short century ends in a quad of four common years.
        s6_last_next = !cyc.jul && (s6_cent_next != dn2cd_pkg::LAST_CENT_IDX)
                       && (s6_m_next >= dn2cd_pkg::CENT_LAST_QUAD);
    end

    // Quad estimate by the scaled reciprocal of 1461.
    assign s7_prod = {22'd0, s6_m_reg} * {16'd0, dn2cd_pkg::RECIP_QUAD};

    // Remainder of the estimate.
    always_comb
    begin
        s8_back = {11'd0, s7_qe_reg} * dn2cd_pkg::QUAD_DAYS[15:0];
        s8_diff = s7_m_reg - s8_back;
    end

    // Correct the quad index, or take the short last quad of the century.
    always_comb
    begin
        s9_rsub = s8_r_reg - dn2cd_pkg::QUAD_DAYS[11:0];
        s9_msub = s8_m_reg - dn2cd_pkg::CENT_LAST_QUAD;
        if (s8_last_reg)
        begin
            s9_quad_next = dn2cd_pkg::LAST_QUAD_IDX;
            s9_rq_next   = s9_msub[10:0];
        end
        else if (s8_r_reg >= dn2cd_pkg::QUAD_DAYS[11:0])
        begin
            s9_quad_next = s8_qe_reg + 5'd1;
            s9_rq_next   = s9_rsub[10:0];
        end
        else
        begin
            s9_quad_next = s8_qe_reg;
            s9_rq_next   = s8_r_reg[10:0];
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_valid_reg <= cyc.valid;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    // Payload of the stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_jul_reg  <= cyc.jul;
            s6_q_reg    <= cyc.q;
            s6_cent_reg <= s6_cent_next;
            s6_m_reg    <= s6_m_next;
            s6_last_reg <= s6_last_next;

            s7_jul_reg  <= s6_jul_reg;
            s7_q_reg    <= s6_q_reg;
            s7_cent_reg <= s6_cent_reg;
            s7_m_reg    <= s6_m_reg;
            s7_last_reg <= s6_last_reg;
            s7_qe_reg   <= s7_prod[36:32];

            s8_jul_reg  <= s7_jul_reg;
            s8_q_reg    <= s7_q_reg;
            s8_cent_reg <= s7_cent_reg;
            s8_m_reg    <= s7_m_reg;
            s8_last_reg <= s7_last_reg;
            s8_qe_reg   <= s7_qe_reg;
            s8_r_reg    <= s8_diff[11:0];

            s9_jul_reg  <= s8_jul_reg;
            s9_q_reg    <= s8_q_reg;
            s9_cent_reg <= s8_cent_reg;
            s9_quad_reg <= s9_quad_next;
            s9_rq_reg   <= s9_rq_next;
        end
    end

    assign qo.valid = s9_valid_reg;
    assign qo.jul   = s9_jul_reg;
    assign qo.q     = s9_q_reg;
    assign qo.cent  = s9_cent_reg;
    assign qo.quad  = s9_quad_reg;
    assign qo.rq    = s9_rq_reg;

endmodule

// ----- src/dn2cd_date_build.sv -----
`timescale 1ns / 1ps

module dn2cd_date_build (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  dn2cd_pkg::quad_t    qi,
    output logic                out_valid,
    output logic signed [13:0]  year,
    output logic [3:0]          month,
    output logic [4:0]          day
);

    logic        s10_valid_reg;
    logic [13:0] s10_year_reg;
    logic [8:0]  s10_doy_reg;
    logic        s10_leap_reg;

    logic        s11_valid_reg;
    logic [13:0] s11_year_reg;
    logic [3:0]  s11_month_reg;
    logic [4:0]  s11_day_reg;

    logic [10:0] t1;
    logic [10:0] t2;
    logic [10:0] t3;
    logic [1:0]  yi;
    logic [10:0] ystart;
    logic [10:0] doy_full;
    logic [13:0] year_jul;
    logic [13:0] year_greg;
    logic [13:0] s10_year_next;
    logic        s10_leap_next;
    logic [3:0]  s11_month_next;
    logic [8:0]  mstart;
    logic [8:0]  s11_diff;
    logic [4:0]  s11_day_next;

    // Year within the quad; a Julian quad opens with its leap year.
    always_comb
    begin
        t1 = qi.jul ? 11'd366 : 11'd365;
        t2 = qi.jul ? 11'd731 : 11'd730;
        t3 = qi.jul ? 11'd1096 : 11'd1095;
        if (qi.rq >= t3)
        begin
            yi     = 2'd3;
            ystart = t3;
        end
        else if (qi.rq >= t2)
        begin
            yi     = 2'd2;
            ystart = t2;
        end
        else if (qi.rq >= t1)
        begin
            yi     = 2'd1;
            ystart = t1;
        end
        else
        begin
            yi     = 2'd0;
            ystart = 11'd0;
        end
        doy_full = qi.rq - ystart;
    end

    // Leap flag and year number from the cycle, century and quad indexes.
    always_comb
    begin
        year_jul  = {1'b0, qi.q, 2'b00} + {12'd0, yi} - dn2cd_pkg::JUL_YEAR0;
        year_greg = 14'd1 + {3'd0, qi.q} * 14'd400 + {12'd0, qi.cent} * 14'd100
                    + {7'd0, qi.quad, 2'b00} + {12'd0, yi};
        if (qi.jul)
        begin
            s10_year_next = year_jul;
            s10_leap_next = (yi == 2'd0);
        end
        else
        begin
            s10_year_next = year_greg;
            s10_leap_next = (yi == 2'd3) && !((qi.quad == dn2cd_pkg::LAST_QUAD_IDX)
                            && (qi.cent != dn2cd_pkg::LAST_CENT_IDX));
        end
    end

    // Month by the last month start not beyond the day of year.
    always_comb
    begin
        s11_month_next = 4'd1;
        mstart         = 9'd0;
        for (int j = 1; j < 12; j++)
        begin
            if (s10_doy_reg >= dn2cd_pkg::month_start(s10_leap_reg, 4'(j)))
            begin
                s11_month_next = 4'(j + 1);
                mstart         = dn2cd_pkg::month_start(s10_leap_reg, 4'(j));
            end
        end
        s11_diff     = s10_doy_reg - mstart;
        s11_day_next = s11_diff[4:0] + 5'd1;
    end

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s10_valid_reg <= qi.valid;
            s11_valid_reg <= s10_valid_reg;
        end
    end

    // Payload of the stages; the last stage is the output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_year_reg  <= s10_year_next;
            s10_doy_reg   <= doy_full[8:0];
            s10_leap_reg  <= s10_leap_next;

            s11_year_reg  <= s10_year_reg;
            s11_month_reg <= s11_month_next;
            s11_day_reg   <= s11_day_next;
        end
    end

    assign out_valid = s11_valid_reg;
    assign year      = s11_year_reg;
    assign month     = s11_month_reg;
    assign day       = s11_day_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // Calendar constants for the date predictor.
    localparam int unsigned SWITCH_DAY       = 2299161;  // 15 Oct 1582, first Gregorian day
    localparam int unsigned PROLEPTIC_DAY1   = 1721426;  // 1 Jan of year 1, Gregorian count
    localparam int unsigned CYCLE_LEN        = 146097;
    localparam int unsigned LAST_CENT_START  = 109572;
    localparam int unsigned CENT_LEN         = 36524;
    localparam int unsigned SHORT_QUAD_START = 35064;
    localparam int unsigned QUAD_LEN         = 1461;
    localparam int          JULIAN_YEAR0     = -4712;

    localparam int NUM_ROWS        = 22;
    localparam int RANDOM_PER_PASS = 200;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int TAIL_CYCLES     = 30;

    // One converted date, tagged with the day number it came from.
    typedef struct packed {
        logic [21:0]        dn;
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } date_t;

    // A directed stimulus row; known marks rows whose date is typed in.
    typedef struct packed {
        logic [21:0]        dn;
        logic               known;
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } row_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [21:0]        day_number = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [13:0] year;
    logic [3:0]         month;
    logic [4:0]         day;

    date_t pending_dates[$];
    int    failures = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;

    // Edges of the calendar: leap days, year and quad ends, the calendar switch,
    // century and 400-year boundaries, and the largest input.
    row_t directed_rows [NUM_ROWS] = '{
        '{22'd0,       1'b1, -14'sd4712, 4'd1,  5'd1},
        '{22'd59,      1'b1, -14'sd4712, 4'd2,  5'd29},
        '{22'd60,      1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd365,     1'b1, -14'sd4712, 4'd12, 5'd31},
        '{22'd366,     1'b1, -14'sd4711, 4'd1,  5'd1},
        '{22'd1460,    1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd1461,    1'b1, -14'sd4708, 4'd1,  5'd1},
        '{22'h155555,  1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd1721423, 1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd1721426, 1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd2299160, 1'b1, 14'sd1582,  4'd10, 5'd4},
        '{22'd2299161, 1'b1, 14'sd1582,  4'd10, 5'd15},
        '{22'd2305813, 1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd2415020, 1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd2415079, 1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd2451544, 1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd2451545, 1'b1, 14'sd2000,  4'd1,  5'd1},
        '{22'd2451604, 1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd2451910, 1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'h2AAAAA,  1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd4194302, 1'b0, 14'sd0,     4'd0,  5'd0},
        '{22'd4194303, 1'b0, 14'sd0,     4'd0,  5'd0}
    };

    day_number_to_calendar_date_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .day_number (day_number),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .year       (year),
        .month      (month),
        .day        (day)
    );

    function automatic bit gregorian_leap(input int unsigned yr);
        if (yr % 100 == 0)
            return (yr % 400) == 0;
        return (yr % 4) == 0;
    endfunction

    // Converts a day number to its date: Julian quads before the switch,
    // Gregorian 400/100/4-year cycles from it on, then a month walk.
    function automatic date_t date_of_day(input logic [21:0] dn);
        int unsigned n;
        int unsigned y;
        int unsigned q;
        int unsigned idx;
        int unsigned span;
        int unsigned mon;
        int          k;
        int          jul_year;
        bit          leap;
        date_t       res;
        n = dn;
        res.dn = dn;
        if (n < SWITCH_DAY)
        begin
            // Each Julian quad starts with its leap year.
            q = n / QUAD_LEN;
            n = n % QUAD_LEN;
            idx = 0;
            for (k = 0; k < 3; k++)
            begin
                span = (idx == 0) ? 366 : 365;
                if (n < span)
                    break;
                n -= span;
                idx++;
            end
            jul_year = int'(4 * q + idx) + JULIAN_YEAR0;
            res.year = jul_year[13:0];
            leap = (idx == 0);
        end
        else
        begin
            n = n - PROLEPTIC_DAY1;
            y = 1 + (n / CYCLE_LEN) * 400;
            n = n % CYCLE_LEN;
            if (n >= LAST_CENT_START)
            begin
                // The last century of a cycle holds the extra leap day.
                y += 300;
                n -= LAST_CENT_START;
                y += (n / QUAD_LEN) * 4;
                n = n % QUAD_LEN;
            end
            else
            begin
                y += (n / CENT_LEN) * 100;
                n = n % CENT_LEN;
                if (n >= SHORT_QUAD_START)
                begin
                    // Short last quad of a century without a leap century year.
                    y += 96;
                    n -= SHORT_QUAD_START;
                end
                else
                begin
                    y += (n / QUAD_LEN) * 4;
                    n = n % QUAD_LEN;
                end
            end
            for (k = 0; k < 4; k++)
            begin
                span = gregorian_leap(y) ? 366 : 365;
                if (n < span)
                    break;
                n -= span;
                y++;
            end
            res.year = y[13:0];
            leap = gregorian_leap(y);
        end
        mon = 1;
        for (k = 0; k < 11; k++)
        begin
            case (mon)
                2:           span = leap ? 29 : 28;
                4, 6, 9, 11: span = 30;
                default:     span = 31;
            endcase
            if (n < span)
                break;
            n -= span;
            mon++;
        end
        res.month = mon[3:0];
        res.day = 5'(n + 1);
        return res;
    endfunction

    // Offers one item, waits for its acceptance, and records the date it must give.
    task automatic send_day(input logic [21:0] dn, input bit known, input date_t typed_date);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        day_number <= dn;
        do
            @(posedge clk);
        while (!in_ready);
        pending_dates.push_back(known ? typed_date : date_of_day(dn));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result checking and receiver stalls.
    always @(posedge clk)
    begin : check_dates
        date_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, got %0d-%0d-%0d",
                         $time, year, month, day);
                failures++;
            end
            else
            begin
                want = pending_dates.pop_front();
                if (year !== want.year)
                begin
                    $display("%0t: year for day %0d: expected %0d, actual %0d",
                             $time, want.dn, $signed(want.year), year);
                    failures++;
                end
                if (month !== want.month)
                begin
                    $display("%0t: month for day %0d: expected %0d, actual %0d",
                             $time, want.dn, want.month, month);
                    failures++;
                end
                if (day !== want.day)
                begin
                    $display("%0t: day for day %0d: expected %0d, actual %0d",
                             $time, want.dn, want.day, day);
                    failures++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stimulus: directed rows first, then three passes of random items
    // with different idling on either side.
    initial
    begin : stimulus
        date_t       typed_date;
        logic [21:0] pick;
        int          pass;
        int          i;
        int          waited;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (pass = 0; pass < 3; pass++)
        begin
            case (pass)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 67;
                end
                1:
                begin
                    send_idle_pct = 67;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (pass == 0)
            begin
                for (i = 0; i < NUM_ROWS; i++)
                begin
                    typed_date.dn = directed_rows[i].dn;
                    typed_date.year = directed_rows[i].year;
                    typed_date.month = directed_rows[i].month;
                    typed_date.day = directed_rows[i].day;
                    send_day(directed_rows[i].dn, directed_rows[i].known, typed_date);
                end
            end
            for (i = 0; i < RANDOM_PER_PASS; i++)
            begin
                // Half uniform, the rest near the calendar switch or 400-year ends.
                case ($urandom_range(3))
                    0, 1:    pick = 22'($urandom);
                    2:       pick = 22'(SWITCH_DAY - 2048 + $urandom_range(4095));
                    default: pick = 22'(PROLEPTIC_DAY1 + $urandom_range(16, 1) * CYCLE_LEN
                                        - 800 + $urandom_range(1600));
                endcase
                send_day(pick, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        // Drain the pipeline, then give any stray item time to show up.
        waited = 0;
        while (pending_dates.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_dates.size() != 0)
        begin
            $display("%0t: %0d dates never arrived, first for day %0d",
                     $time, pending_dates.size(), pending_dates[0].dn);
            failures++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("%0t: run timed out", $time);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
